[src/sdf_pkg.sv]
// Shared types, constants and the sine table generator for the sine DDS DAC feeder.
package sdf_pkg;

  // Command word sent to the DAC: four control bits over twelve code bits
  localparam int CmdBits  = 16;
  localparam int CodeBits = 12;
  localparam int NibBits  = 4;
  localparam int StepBits = 16;

  // Configuration port
  localparam int CfgIdxBits  = 8;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CfgPhaseStep  = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgAmplitude  = 8'd1;
  localparam logic [CfgIdxBits-1:0] CfgOffset     = 8'd2;
  localparam logic [CfgIdxBits-1:0] CfgControlNib = 8'd3;

  localparam logic [StepBits-1:0] PhaseStepRst = 16'd2621;
  localparam logic [CodeBits-1:0] AmplitudeRst = 12'd1000;
  localparam logic [CodeBits-1:0] OffsetRst    = 12'd1000;
  localparam logic [NibBits-1:0]  ControlRst   = 4'd1;

  // Signed Q1.15 sine sample, one extra bit so that the 16-bit table magnitude can be zero-extended and negated
  localparam int SineBits = 17;
  typedef logic signed [SineBits-1:0] sine_t;

  // Magnitude stored in the quarter-wave table
  localparam int MagBits = 16;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Quarter-wave entry k of a table with 2^addr_bits steps, Q1.15, evaluated at
  // elaboration: Q30 Taylor series of sin up to x^15, rounded, clamped to 32767
  function automatic logic [MagBits-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned addr_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (HalfPiQ30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return MagBits'(v);
  endfunction

endpackage

[src/sine_dds_spi_dac_feeder.sv]
// Top level: phase accumulator, sine scaling and saturation, 16-bit serial command output.
// A transferred tick passes stage 1, stage 2 and the holding slot before its first command bit (bit 15) shows.
// The serializer sends one bit per cycle while out_stall_i is low; new ticks are taken while a word is sent.
// A tick with value 0 is taken and gives no output.
// Three samples queue behind the serializer before in_stall_o rises.
// Reset (rst_ni low, asynchronous) clears the phase and all valids and loads register defaults.
module sine_dds_spi_dac_feeder #(
  parameter int PHASE_BITS      = 16,
  parameter int TABLE_ADDR_BITS = 8,
  parameter int DAC_BITS        = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sdf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [sdf_pkg::CfgDataBits-1:0] cfg_data_i,
  // tick input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            tick_i,
  // serial bit output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sdi_bit_o,
  output logic [3:0]                      bit_index_o,
  output logic                            last_bit_o,
  output logic [sdf_pkg::CodeBits-1:0]    sample_code_o,
  output logic                            clipped_o
);
  import sdf_pkg::*;

  localparam int IdxBits  = TABLE_ADDR_BITS + 2;
  localparam int SumBits  = 30;
  localparam int Shift    = 15 + CodeBits - DAC_BITS;
  localparam int AlignSh  = CodeBits - DAC_BITS;
  localparam logic [DAC_BITS-1:0] MaxCode = {DAC_BITS{1'b1}};

  // ---------------- configuration registers ----------------
  logic [StepBits-1:0] phase_step_q;
  logic [CodeBits-1:0] amp_q;
  logic [CodeBits-1:0] off_q;
  logic [NibBits-1:0]  nib_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PhaseStepRst;
      amp_q        <= AmplitudeRst;
      off_q        <= OffsetRst;
      nib_q        <= ControlRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPhaseStep:  phase_step_q <= cfg_data_i[StepBits-1:0];
        CfgAmplitude:  amp_q        <= cfg_data_i[CodeBits-1:0];
        CfgOffset:     off_q        <= cfg_data_i[CodeBits-1:0];
        CfgControlNib: nib_q        <= cfg_data_i[NibBits-1:0];
        default:       ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic s1_valid_q, s2_valid_q, hold_valid_q, ser_valid_q;
  logic s1_ready, s2_ready, hold_ready;
  logic in_xfer, out_xfer, ser_load;
  logic [3:0] ser_idx_q;

  assign out_xfer   = ser_valid_q && !out_stall_i;
  assign ser_load   = hold_valid_q && (!ser_valid_q || (out_xfer && ser_idx_q == 4'd0));
  assign hold_ready = !hold_valid_q || ser_load;
  assign s2_ready   = !s2_valid_q || hold_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------- stage 1: phase accumulator ----------------
  logic [PHASE_BITS-1:0] phase_accum_q, phase_accum_d;
  logic [PHASE_BITS-1:0] s1_phase_q;

  assign phase_accum_d = phase_accum_q + PHASE_BITS'(phase_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_accum_q <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (in_xfer && tick_i) begin
        phase_accum_q <= phase_accum_d;
      end
      if (s1_ready) begin
        s1_valid_q <= in_xfer && tick_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && tick_i) begin
      s1_phase_q <= phase_accum_d;
    end
  end

  // ---------------- stage 2: sine lookup ----------------
  logic [IdxBits-1:0] tab_idx;
  sine_t              sine_w;
  sine_t              s2_sine_q;

  if (PHASE_BITS >= IdxBits) begin : g_idx_trunc
    assign tab_idx = s1_phase_q[PHASE_BITS-1 -: IdxBits];
  end else begin : g_idx_pad
    assign tab_idx = {s1_phase_q, {(IdxBits-PHASE_BITS){1'b0}}};
  end

  sdf_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .idx_i (tab_idx),
    .sine_o(sine_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_sine_q <= sine_w;
    end
  end

  // ---------------- stage 3: scale, offset, saturate ----------------
  logic signed [SumBits-1:0] prod, off_term, sum, shifted;
  logic [DAC_BITS-1:0]       code_dac;
  logic [CodeBits-1:0]       code_d;
  logic                      clip_d;
  logic [CmdBits-1:0]        cmd_d;

  assign prod     = SumBits'($signed({1'b0, amp_q})) * SumBits'(s2_sine_q);
  assign off_term = $signed(SumBits'({off_q, 15'b0}));
  assign sum      = off_term + prod;
  assign shifted  = sum >>> Shift;

  always_comb begin
    if (sum < 0) begin
      code_dac = '0;
      clip_d   = 1'b1;
    end else if (shifted > $signed(SumBits'(MaxCode))) begin
      code_dac = MaxCode;
      clip_d   = 1'b1;
    end else begin
      code_dac = DAC_BITS'(shifted);
      clip_d   = 1'b0;
    end
  end

  assign code_d = CodeBits'(code_dac);
  assign cmd_d  = {nib_q, CodeBits'(code_d << AlignSh)};

  // Holding slot between the arithmetic and the serializer
  logic [CmdBits-1:0]  hold_cmd_q;
  logic [CodeBits-1:0] hold_code_q;
  logic                hold_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (hold_ready) begin
      hold_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && hold_ready) begin
      hold_cmd_q  <= cmd_d;
      hold_code_q <= code_d;
      hold_clip_q <= clip_d;
    end
  end

  // ---------------- serializer: bit 15 down to bit 0 ----------------
  logic [CmdBits-1:0]  ser_cmd_q;
  logic [CodeBits-1:0] ser_code_q;
  logic                ser_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= 4'd15;
    end else if (ser_load) begin
      ser_valid_q <= 1'b1;
      ser_idx_q   <= 4'd15;
    end else if (out_xfer) begin
      if (ser_idx_q == 4'd0) begin
        ser_valid_q <= 1'b0;
      end else begin
        ser_idx_q <= ser_idx_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_cmd_q  <= hold_cmd_q;
      ser_code_q <= hold_code_q;
      ser_clip_q <= hold_clip_q;
    end
  end

  assign out_valid_o   = ser_valid_q;
  assign sdi_bit_o     = ser_cmd_q[ser_idx_q];
  assign bit_index_o   = ser_idx_q;
  assign last_bit_o    = (ser_idx_q == 4'd0);
  assign sample_code_o = ser_code_q;
  assign clipped_o     = ser_clip_q;

  // ---------------- assertions ----------------
  // Bit index steps down by one on each transfer within a word
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && ser_idx_q != 4'd0 |=> ser_valid_q && ser_idx_q == $past(ser_idx_q) - 4'd1)
    else $error("serializer bit index did not step down");

  // The command word stays put until its last bit is sent
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q && !(out_xfer && ser_idx_q == 4'd0) |=> $stable(ser_cmd_q) && ser_valid_q)
    else $error("command word changed mid-word");

  // A waiting sample is never overwritten
  a_hold_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q && !ser_load |=> hold_valid_q && $stable(hold_cmd_q))
    else $error("holding slot overwritten");

  // A clipped sample sits at one end of the code range
  a_clip_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q && ser_clip_q |->
      ser_code_q == '0 || ser_code_q == CodeBits'(MaxCode))
    else $error("clipped sample not at a range limit");

  // A new word starts at bit 15
  a_word_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |=> ser_idx_q == 4'd15)
    else $error("word did not start at bit 15");

endmodule

[src/sdf_sine_rom.sv]
// Quarter-wave sine table with quadrant folding: phase index in, signed Q1.15 sine out.
module sdf_sine_rom #(
  parameter int TABLE_ADDR_BITS = 8
) (
  input  logic [TABLE_ADDR_BITS+1:0] idx_i,
  output sdf_pkg::sine_t             sine_o
);
  import sdf_pkg::*;

  localparam int TabN = 1 << TABLE_ADDR_BITS;

  // Constant table, entries 0 .. TabN inclusive
  logic [MagBits-1:0] tab [TabN+1];

  for (genvar k = 0; k <= TabN; k++) begin : g_tab
    assign tab[k] = sine_entry(k, TABLE_ADDR_BITS);
  end

  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [TABLE_ADDR_BITS:0]   addr_fwd;
  logic [TABLE_ADDR_BITS:0]   addr_mir;
  logic [MagBits-1:0]         mag;
  sine_t                      mag_s;

  assign quad     = idx_i[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  assign addr     = idx_i[TABLE_ADDR_BITS-1:0];
  assign addr_fwd = {1'b0, addr};
  assign addr_mir = (TABLE_ADDR_BITS+1)'(TabN) - addr_fwd;

  // Odd quadrants run the table backwards, upper half-cycle negates
  assign mag    = quad[0] ? tab[addr_mir] : tab[addr_fwd];
  assign mag_s  = $signed({1'b0, mag});
  assign sine_o = quad[1] ? -mag_s : mag_s;

endmodule
